[rtl/vertex_wave_deform_core_macros.svh]
// Assertion macros for the vertex wave deform core.
// No dependencies; included by the top level.
`ifndef VERTEX_WAVE_DEFORM_CORE_MACROS_SVH
`define VERTEX_WAVE_DEFORM_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define VWD_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define VWD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/vwd_pkg.sv]
// Package for the vertex wave deform core: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package vwd_pkg;

    localparam int DEF_TABLE_SIZE = 1024;
    localparam longint INV_TWO_PI_Q32 = 683565276;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_SELECT    = 3'd0;
    localparam logic [2:0] REG_BASE      = 3'd1;
    localparam logic [2:0] REG_AMPLITUDE = 3'd2;
    localparam logic [2:0] REG_PHASE     = 3'd3;
    localparam logic [2:0] REG_FREQUENCY = 3'd4;
    localparam logic [2:0] REG_ARG0      = 3'd5;
    localparam logic [2:0] REG_ARG1      = 3'd6;
    localparam logic [2:0] REG_ARG2      = 3'd7;

    // Deform modes
    localparam logic [2:0] MODE_WAVE  = 3'd1;
    localparam logic [2:0] MODE_MOVE  = 3'd3;
    localparam logic [2:0] MODE_BULGE = 3'd4;

    // Waveforms
    localparam logic [2:0] WF_SINE     = 3'd0;
    localparam logic [2:0] WF_TRIANGLE = 3'd1;
    localparam logic [2:0] WF_SQUARE   = 3'd2;
    localparam logic [2:0] WF_SAW      = 3'd3;
    localparam logic [2:0] WF_INV_SAW  = 3'd4;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_WAVE,
        OP_MOVE,
        OP_BULGE
    } op_t;

    // Vertex data that rides along the pipeline
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               last;
        op_t                op;
    } carry_t;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/vertex_wave_deform_core.sv]
// Top level of the vertex wave deform core: ten-stage pipeline with waveform ROMs.
// Depends on vwd_pkg and vertex_wave_deform_core_macros.svh.
`timescale 1ns / 1ps
//
//  channel | dir | signals                          | word
//  --------+-----+----------------------------------+-------------------------
//  s       | in  | s_tvalid s_tready s_tdata s_tuser| one vertex, tlast = mesh end
//  m       | out | m_tvalid m_tready m_tdata m_tlast| one deformed vertex
//  cfg     | in  | cfg_we cfg_addr cfg_data         | one register write
//
//  One vertex enters per cycle while the output is not stalled; each result
//  moves through the registered stages of the multiply and table pipeline
//  and is presented from the last stage's registers.
//  Reset clears stage valid bits and config registers, not payload; no clearing pass.
//  Each stage holds its word only while the stage after it is full and
//  stalled, so bubbles close up and input is taken while a result waits.

`include "vertex_wave_deform_core_macros.svh"

module vertex_wave_deform_core #(
    parameter int TABLE_SIZE = vwd_pkg::DEF_TABLE_SIZE
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, frame_time
    input  logic [207:0] s_tdata,
    // has_normals
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z
    output logic [95:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_data
);

    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int NST = 10;
    localparam int TW  = 16 + IW;

    // Sine quarter-wave polynomial, folded to the full turn
    function automatic logic signed [17:0] sine_entry(int i);
        longint r, quad, f, u, u2, p, v;
        r    = 4 * longint'(i);
        quad = r / TABLE_SIZE;
        f    = r % TABLE_SIZE;
        if (quad % 2 == 1)
            f = TABLE_SIZE - f;
        u  = (f * (longint'(1) << 30)) / TABLE_SIZE;
        u2 = (u * u) >>> 30;
        p  = 172273;
        p  = 5026994 - ((u2 * p) >>> 30);
        p  = 85569306 - ((u2 * p) >>> 30);
        p  = 693598668 - ((u2 * p) >>> 30);
        p  = 1686629713 - ((u2 * p) >>> 30);
        v  = (u * p) >>> 30;
        v  = (v + 8192) >>> 14;
        if (v > 65536)
            v = 65536;
        if (quad >= 2)
            v = -v;
        return v[17:0];
    endfunction

    function automatic logic signed [17:0] tri_entry(int i);
        longint i4, v4, v;
        i4 = 4 * longint'(i);
        v4 = (i4 * 65536) / TABLE_SIZE;
        if (i4 < TABLE_SIZE)
            v = v4;
        else if (i4 < 3 * TABLE_SIZE)
            v = 131072 - v4;
        else
            v = v4 - 262144;
        return v[17:0];
    endfunction

    function automatic logic signed [17:0] saw_entry(int i);
        longint v;
        v = (longint'(i) * 65536) / TABLE_SIZE;
        return v[17:0];
    endfunction

    logic signed [17:0] sine_rom [TABLE_SIZE];
    logic signed [17:0] tri_rom  [TABLE_SIZE];
    logic signed [17:0] saw_rom  [TABLE_SIZE];

    // Fill the waveform ROMs with constants
    for (genvar g = 0; g < TABLE_SIZE; g++)
    begin : g_rom
        assign sine_rom[g] = sine_entry(g);
        assign tri_rom[g]  = tri_entry(g);
        assign saw_rom[g]  = saw_entry(g);
    end

    // Configuration registers
    logic [5:0]         select_reg;
    logic signed [31:0] base_reg, amp_reg, phase_reg, freq_reg;
    logic signed [31:0] arg0_reg, arg1_reg, arg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg <= '0;
            base_reg   <= '0;
            amp_reg    <= '0;
            phase_reg  <= '0;
            freq_reg   <= '0;
            arg0_reg   <= '0;
            arg1_reg   <= '0;
            arg2_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                vwd_pkg::REG_SELECT:    select_reg <= cfg_data[5:0];
                vwd_pkg::REG_BASE:      base_reg   <= cfg_data;
                vwd_pkg::REG_AMPLITUDE: amp_reg    <= cfg_data;
                vwd_pkg::REG_PHASE:     phase_reg  <= cfg_data;
                vwd_pkg::REG_FREQUENCY: freq_reg   <= cfg_data;
                vwd_pkg::REG_ARG0:      arg0_reg   <= cfg_data;
                vwd_pkg::REG_ARG1:      arg1_reg   <= cfg_data;
                vwd_pkg::REG_ARG2:      arg2_reg   <= cfg_data;
                default:                select_reg <= select_reg;
            endcase
        end
    end

    // Stage valid bits and per-stage ready
    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;

    always_comb
    begin
        rdy[NST-1] = !v_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign s_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Unpack the input word and pick the operation
    vwd_pkg::carry_t    in_c;
    logic signed [31:0] in_s, in_t;

    always_comb
    begin
        in_c.pos_x  = s_tdata[31:0];
        in_c.pos_y  = s_tdata[63:32];
        in_c.pos_z  = s_tdata[95:64];
        in_c.norm_x = s_tdata[111:96];
        in_c.norm_y = s_tdata[127:112];
        in_c.norm_z = s_tdata[143:128];
        in_c.last   = s_tlast;
        in_s        = s_tdata[175:144];
        in_t        = s_tdata[207:176];
        priority if (select_reg[2:0] == vwd_pkg::MODE_WAVE && s_tuser[0])
            in_c.op = vwd_pkg::OP_WAVE;
        else if (select_reg[2:0] == vwd_pkg::MODE_MOVE)
            in_c.op = vwd_pkg::OP_MOVE;
        else if (select_reg[2:0] == vwd_pkg::MODE_BULGE)
            in_c.op = vwd_pkg::OP_BULGE;
        else
            in_c.op = vwd_pkg::OP_PASS;
    end

    vwd_pkg::carry_t carry_reg [NST];

    // Pipeline payload
    logic signed [33:0]   sum0_reg;
    logic signed [63:0]   ft0_reg, bs0_reg, bt0_reg;
    logic signed [49:0]   sa1_reg;
    logic signed [48:0]   sb1_reg, r1_reg;
    logic signed [63:0]   ft1_reg, ft2_reg;
    logic signed [50:0]   spread2_reg;
    logic signed [63:0]   rhc2_reg;
    logic signed [46:0]   rlc2_reg;
    logic signed [63:0]   turns3_reg;
    logic [IW-1:0]        idx4_reg;
    logic [2:0]           wf4_reg, wf5_reg;
    logic signed [17:0]   sine5_reg, tri5_reg, saw5_reg;
    logic                 sq5_reg;
    logic signed [49:0]   vp6_reg;
    logic signed [31:0]   d7_reg;
    logic signed [63:0]   m8_reg [3];
    logic signed [31:0]   res9_reg [3];

    logic signed [63:0]   turns3_next;
    logic [TW-1:0]        q4_next;
    logic [IW-1:0]        idx4_next;
    logic signed [17:0]   tv6_next;
    logic signed [31:0]   f8_next [3];
    logic signed [31:0]   p9 [3];
    logic signed [63:0]   sh9 [3];

    // Phase sum of the waveform or the bulge angle in turns
    always_comb
    begin
        unique case (carry_reg[2].op)
            vwd_pkg::OP_BULGE:
                turns3_next = (rhc2_reg + 64'(rlc2_reg >>> 16)) >>> 16;
            vwd_pkg::OP_WAVE:
                turns3_next = 64'(spread2_reg) + 64'(phase_reg) + (ft2_reg >>> 16);
            default:
                turns3_next = 64'(phase_reg) + (ft2_reg >>> 16);
        endcase
    end

    // Scale turns to a table index, truncated toward zero
    always_comb
    begin
        q4_next   = TW'(turns3_reg[TW-1:0] * TW'(TABLE_SIZE))
                  + (turns3_reg[63] ? TW'(16'hFFFF) : TW'(0));
        idx4_next = q4_next[TW-1:16] & IW'(TABLE_SIZE - 1);
    end

    // Select the waveform value
    always_comb
    begin
        unique case (wf5_reg)
            vwd_pkg::WF_SINE:     tv6_next = sine5_reg;
            vwd_pkg::WF_TRIANGLE: tv6_next = tri5_reg;
            vwd_pkg::WF_SQUARE:   tv6_next = sq5_reg ? 18'sd65536 : -18'sd65536;
            vwd_pkg::WF_SAW:      tv6_next = saw5_reg;
            vwd_pkg::WF_INV_SAW:  tv6_next = 18'sd65536 - saw5_reg;
            default:              tv6_next = '0;
        endcase
    end

    // Factors of the final offset and the shifted offsets
    always_comb
    begin
        if (carry_reg[7].op == vwd_pkg::OP_MOVE)
        begin
            f8_next[0] = arg0_reg;
            f8_next[1] = arg1_reg;
            f8_next[2] = arg2_reg;
        end
        else
        begin
            f8_next[0] = 32'(carry_reg[7].norm_x);
            f8_next[1] = 32'(carry_reg[7].norm_y);
            f8_next[2] = 32'(carry_reg[7].norm_z);
        end
        p9[0] = carry_reg[8].pos_x;
        p9[1] = carry_reg[8].pos_y;
        p9[2] = carry_reg[8].pos_z;
        for (int k = 0; k < 3; k++)
            sh9[k] = (carry_reg[8].op == vwd_pkg::OP_MOVE) ? (m8_reg[k] >>> 16)
                                                           : (m8_reg[k] >>> 14);
    end

    always_ff @(posedge clk)
    begin
        // Stage 0: coordinate sum and time products
        if (rdy[0])
        begin
            carry_reg[0] <= in_c;
            sum0_reg     <= 34'(in_c.pos_x) + 34'(in_c.pos_y) + 34'(in_c.pos_z);
            ft0_reg      <= 64'(freq_reg) * 64'(in_t);
            bs0_reg      <= 64'(in_s) * 64'(arg0_reg);
            bt0_reg      <= 64'(in_t) * 64'(arg2_reg);
        end
        // Stage 1: spread partial products, bulge angle
        if (rdy[1])
        begin
            carry_reg[1] <= carry_reg[0];
            sa1_reg      <= 50'(arg0_reg) * 50'($signed(sum0_reg[33:16]));
            sb1_reg      <= 49'(arg0_reg) * 49'($signed({1'b0, sum0_reg[15:0]}));
            r1_reg       <= 49'(bs0_reg >>> 16) + 49'(bt0_reg >>> 16);
            ft1_reg      <= ft0_reg;
        end
        // Stage 2: spread, angle times one over two pi
        if (rdy[2])
        begin
            carry_reg[2] <= carry_reg[1];
            spread2_reg  <= 51'(sa1_reg) + 51'(sb1_reg >>> 16);
            rhc2_reg     <= 64'($signed(r1_reg[48:16])) * vwd_pkg::INV_TWO_PI_Q32;
            rlc2_reg     <= 47'(64'($signed({1'b0, r1_reg[15:0]}))
                            * vwd_pkg::INV_TWO_PI_Q32);
            ft2_reg      <= ft1_reg;
        end
        // Stage 3: turns
        if (rdy[3])
        begin
            carry_reg[3] <= carry_reg[2];
            turns3_reg   <= turns3_next;
        end
        // Stage 4: table index
        if (rdy[4])
        begin
            carry_reg[4] <= carry_reg[3];
            idx4_reg     <= idx4_next;
            wf4_reg      <= (carry_reg[3].op == vwd_pkg::OP_BULGE) ? vwd_pkg::WF_SINE
                                                                   : select_reg[5:3];
        end
        // Stage 5: ROM read
        if (rdy[5])
        begin
            carry_reg[5] <= carry_reg[4];
            sine5_reg    <= sine_rom[idx4_reg];
            tri5_reg     <= tri_rom[idx4_reg];
            saw5_reg     <= saw_rom[idx4_reg];
            sq5_reg      <= ({1'b0, idx4_reg, 1'b0} < (IW + 2)'(TABLE_SIZE));
            wf5_reg      <= wf4_reg;
        end
        // Stage 6: scale the waveform
        if (rdy[6])
        begin
            carry_reg[6] <= carry_reg[5];
            vp6_reg      <= 50'(tv6_next) * 50'((carry_reg[5].op == vwd_pkg::OP_BULGE)
                                                ? arg1_reg : amp_reg);
        end
        // Stage 7: deflection
        if (rdy[7])
        begin
            carry_reg[7] <= carry_reg[6];
            d7_reg       <= vwd_pkg::sat32(66'(vp6_reg >>> 16)
                            + ((carry_reg[6].op == vwd_pkg::OP_BULGE) ? 66'sd0
                                                                      : 66'(base_reg)));
        end
        // Stage 8: offset products
        if (rdy[8])
        begin
            carry_reg[8] <= carry_reg[7];
            for (int k = 0; k < 3; k++)
                m8_reg[k] <= 64'(d7_reg) * 64'(f8_next[k]);
        end
        // Stage 9: add and saturate, hold for the output
        if (rdy[9])
        begin
            carry_reg[9] <= carry_reg[8];
            for (int k = 0; k < 3; k++)
                res9_reg[k] <= (carry_reg[8].op == vwd_pkg::OP_PASS) ? p9[k]
                               : vwd_pkg::sat32(66'(p9[k]) + 66'(sh9[k]));
        end
    end

    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = {res9_reg[2], res9_reg[1], res9_reg[0]};
    assign m_tlast  = carry_reg[NST-1].last;

    // Pipeline checks
    `VWD_ASSERT_SAME(a_empty_out_ready, !m_tvalid, s_tready, "input blocked with empty output")
    `VWD_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, v_reg[0], "accepted word lost")
    `VWD_ASSERT_NEXT(a_stall_holds, v_reg[0] && !rdy[1], v_reg[0], "stalled stage dropped")

endmodule

[tb/tb_top.sv]
// Self-checking bench for vertex_wave_deform_core: directed table, then random vertices.
// Depends on vwd_pkg and the core RTL; predicts each deformed vertex in-bench.
`timescale 1ns / 1ps

module tb_top;

    localparam int TSIZE = vwd_pkg::DEF_TABLE_SIZE;
    localparam longint ONE = 65536;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic               hn;
        logic signed [31:0] s, tm;
        logic               last;
    } vertex_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               last;
    } dvert_t;

    // Directed row: vertex plus optional typed-in expectation
    typedef struct {
        vertex_t v;
        bit      fixed;
        dvert_t  e;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_data;

    vertex_wave_deform_core dut (.*);

    // Shadow registers
    logic [5:0]    sel_r;
    longint        base_r, amp_r, phase_r, freq_r, a0_r, a1_r, a2_r;

    dvert_t        pending_verts[$];
    int            errors = 0;
    bit            hold_sink = 0;
    bit            calm = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb_top failed");
        $finish;
    end

    function automatic longint floor_shr(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sine_val(int idx);
        longint r, quad, f, u, u2, p, v;
        r = 4 * longint'(idx);
        quad = r / TSIZE;
        f = r % TSIZE;
        if (quad[0]) f = TSIZE - f;
        u = (f * (64'sd1 << 30)) / TSIZE;
        u2 = (u * u) >>> 30;
        p = 172273;
        p = 5026994 - ((u2 * p) >>> 30);
        p = 85569306 - ((u2 * p) >>> 30);
        p = 693598668 - ((u2 * p) >>> 30);
        p = 1686629713 - ((u2 * p) >>> 30);
        v = (u * p) >>> 30;
        v = (v + 8192) >>> 14;
        if (v > ONE) v = ONE;
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic longint wave_table(logic [2:0] wf, int i);
        longint t, v4;
        t = (longint'(i) * ONE) / TSIZE;
        v4 = (4 * longint'(i) * ONE) / TSIZE;
        case (wf)
            vwd_pkg::WF_SINE:     return sine_val(i);
            vwd_pkg::WF_TRIANGLE:
            begin
                if (4 * i < TSIZE) return v4;
                if (4 * i < 3 * TSIZE) return 2 * ONE - v4;
                return v4 - 4 * ONE;
            end
            vwd_pkg::WF_SQUARE:   return (2 * i < TSIZE) ? ONE : -ONE;
            vwd_pkg::WF_SAW:      return t;
            vwd_pkg::WF_INV_SAW:  return ONE - t;
            default:              return 0;
        endcase
    endfunction

    // Truncate toward zero, then mask into the table
    function automatic int table_slot(longint turns);
        longint q;
        q = (turns * TSIZE) / ONE;
        return int'(q & longint'(TSIZE - 1));
    endfunction

    function automatic longint deflection(longint spread, longint tm);
        longint turns;
        turns = spread + phase_r + floor_shr(freq_r * tm, 16);
        return clamp32(floor_shr(wave_table(sel_r[5:3], table_slot(turns)) * amp_r, 16)
                       + base_r);
    endfunction

    function automatic dvert_t deform_vertex(vertex_t v);
        dvert_t o;
        longint p[3], n[3], d, sum, spread, r, turns;
        p[0] = longint'(v.px); p[1] = longint'(v.py); p[2] = longint'(v.pz);
        n[0] = longint'(v.nx); n[1] = longint'(v.ny); n[2] = longint'(v.nz);
        o.x = v.px; o.y = v.py; o.z = v.pz;
        o.last = v.last;
        if (sel_r[2:0] == vwd_pkg::MODE_WAVE && v.hn)
        begin
            sum = p[0] + p[1] + p[2];
            spread = a0_r * floor_shr(sum, 16) + floor_shr(a0_r * (sum & 64'hFFFF), 16);
            d = deflection(spread, longint'(v.tm));
            o.x = 32'(clamp32(p[0] + floor_shr(d * n[0], 14)));
            o.y = 32'(clamp32(p[1] + floor_shr(d * n[1], 14)));
            o.z = 32'(clamp32(p[2] + floor_shr(d * n[2], 14)));
        end
        else if (sel_r[2:0] == vwd_pkg::MODE_MOVE)
        begin
            d = deflection(0, longint'(v.tm));
            o.x = 32'(clamp32(p[0] + floor_shr(d * a0_r, 16)));
            o.y = 32'(clamp32(p[1] + floor_shr(d * a1_r, 16)));
            o.z = 32'(clamp32(p[2] + floor_shr(d * a2_r, 16)));
        end
        else if (sel_r[2:0] == vwd_pkg::MODE_BULGE)
        begin
            r = floor_shr(longint'(v.s) * a0_r, 16) + floor_shr(longint'(v.tm) * a2_r, 16);
            turns = floor_shr(floor_shr(r, 16) * vwd_pkg::INV_TWO_PI_Q32
                              + floor_shr((r & 64'hFFFF) * vwd_pkg::INV_TWO_PI_Q32, 16),
                              16);
            d = clamp32(floor_shr(sine_val(table_slot(turns)) * a1_r, 16));
            o.x = 32'(clamp32(p[0] + floor_shr(d * n[0], 14)));
            o.y = 32'(clamp32(p[1] + floor_shr(d * n[1], 14)));
            o.z = 32'(clamp32(p[2] + floor_shr(d * n[2], 14)));
        end
        return o;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            vwd_pkg::REG_SELECT:    sel_r = val[5:0];
            vwd_pkg::REG_BASE:      base_r = longint'(signed'(val));
            vwd_pkg::REG_AMPLITUDE: amp_r = longint'(signed'(val));
            vwd_pkg::REG_PHASE:     phase_r = longint'(signed'(val));
            vwd_pkg::REG_FREQUENCY: freq_r = longint'(signed'(val));
            vwd_pkg::REG_ARG0:      a0_r = longint'(signed'(val));
            vwd_pkg::REG_ARG1:      a1_r = longint'(signed'(val));
            vwd_pkg::REG_ARG2:      a2_r = longint'(signed'(val));
            default:                a2_r = a2_r;
        endcase
    endtask

    // Drop valid and wait for the pipeline to drain before touching registers
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_verts.size() != 0) @(posedge clk);
        repeat (15) @(posedge clk);
    endtask

    // Offer one word, holding it until accepted
    task automatic send_vertex(vertex_t v, bit fixed, dvert_t e);
        while (!calm && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v.tm, v.s, v.nz, v.ny, v.nx, v.pz, v.py, v.px};
        s_tuser <= v.hn;
        s_tlast <= v.last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_verts.push_back(fixed ? e : deform_vertex(v));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(signed'($urandom_range(2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        v.px = rand_word(); v.py = rand_word(); v.pz = rand_word();
        v.nx = 16'($urandom); v.ny = 16'($urandom); v.nz = 16'($urandom);
        if ($urandom_range(2) == 0)
        begin
            v.nx = 16'sd16384; v.ny = 0; v.nz = -16'sd16384;
        end
        v.hn = ($urandom_range(4) != 0);
        v.s = rand_word(); v.tm = rand_word();
        v.last = ($urandom_range(7) == 0);
        return v;
    endfunction

    task automatic random_config(logic [5:0] sel);
        write_reg(vwd_pkg::REG_SELECT, {26'd0, sel});
        write_reg(vwd_pkg::REG_BASE, rand_word());
        write_reg(vwd_pkg::REG_AMPLITUDE, rand_word());
        write_reg(vwd_pkg::REG_PHASE, rand_word());
        write_reg(vwd_pkg::REG_FREQUENCY, rand_word());
        write_reg(vwd_pkg::REG_ARG0, rand_word());
        write_reg(vwd_pkg::REG_ARG1, rand_word());
        write_reg(vwd_pkg::REG_ARG2, rand_word());
    endtask

    // Sink: random stalls, a calm stretch, and one long hold-off
    initial
    begin
        int stall_cnt;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                for (stall_cnt = 0; stall_cnt < 200; stall_cnt++) @(posedge clk);
                hold_sink = 0;
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        dvert_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verts.size() == 0)
            begin
                $display("%0t: unexpected word %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                e = pending_verts.pop_front();
                if (m_tdata[31:0] !== e.x)
                begin
                    $display("%0t: out_x exp %h got %h", $time, e.x, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.y)
                begin
                    $display("%0t: out_y exp %h got %h", $time, e.y, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== e.z)
                begin
                    $display("%0t: out_z exp %h got %h", $time, e.z, m_tdata[95:64]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $display("%0t: last exp %b got %b", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        dvert_t none_e;
        int i, ph, wait_cnt;
        logic [2:0] mode;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        sel_r = 0;
        base_r = 0; amp_r = 0; phase_r = 0; freq_r = 0; a0_r = 0; a1_r = 0; a2_r = 0;
        none_e = '{0, 0, 0, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset: pass-through with extreme coordinates, typed in
        rw.v = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 16'h7FFF, 16'h8000, 0, 1, 0, 0, 1};
        rw.fixed = 1;
        rw.e = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 1};
        rows.push_back(rw);
        rw.v = '{-1, 1, 32'h1234_5678, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0};
        rw.e = '{-1, 1, 32'h1234_5678, 0};
        rows.push_back(rw);
        foreach (rows[k]) send_vertex(rows[k].v, rows[k].fixed, rows[k].e);
        drain();

        // Every mode and waveform, including unknown ones and no-normal wave
        for (i = 0; i < 16; i++)
        begin
            mode = (i < 8) ? 3'(i) : ((i % 2) ? vwd_pkg::MODE_BULGE : vwd_pkg::MODE_WAVE);
            write_reg(vwd_pkg::REG_SELECT, {26'd0, 3'(i % 8), mode});
            write_reg(vwd_pkg::REG_BASE, (i == 3) ? 32'h7FFF_FFFF : 32'h0000_8000);
            write_reg(vwd_pkg::REG_AMPLITUDE, (i == 5) ? 32'h8000_0000 : 32'h0002_0000);
            write_reg(vwd_pkg::REG_PHASE, 32'h0000_4000);
            write_reg(vwd_pkg::REG_FREQUENCY, 32'h0001_0000);
            write_reg(vwd_pkg::REG_ARG0, 32'h0001_0000);
            write_reg(vwd_pkg::REG_ARG1, 32'h0003_0000);
            write_reg(vwd_pkg::REG_ARG2, 32'hFFFF_0000);
            rw.v = rand_vertex();
            rw.v.hn = (i != 10);
            rw.fixed = 0;
            send_vertex(rw.v, 0, none_e);
            drain();
        end

        // Random phases of random configuration; calm and hold-off in some
        for (ph = 0; ph < 22; ph++)
        begin
            calm = (ph == 4);
            if (ph == 0) random_config(6'h00);
            else if (ph == 1) random_config(6'h3F);
            else random_config(($urandom_range(3) != 0) ?
                               {3'($urandom_range(5)), 3'($urandom_range(7) % 5)}
                               : 6'($urandom));
            if (ph == 7) hold_sink = 1;
            for (i = 0; i < 50; i++) send_vertex(rand_vertex(), 0, none_e);
            drain();
        end
        calm = 0;

        wait_cnt = 0;
        while (pending_verts.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_verts.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
